### rtl/order_free_bitmap_list_defines.svh
// Assertion macros used by the checker file.
`ifndef ORDER_FREE_BITMAP_LIST_DEFINES_SVH
`define ORDER_FREE_BITMAP_LIST_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define OFBL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that a condition holds at every edge out of reset.
`define OFBL_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
        else $error("assertion failed");
`endif

### rtl/ofbl_pkg.sv
// ----------------------------------------------------------------------------
// ofbl_pkg
// Types and codes shared by the order free bitmap list modules.
// ----------------------------------------------------------------------------
package ofbl_pkg;
    localparam logic [1:0] ACT_FREE  = 2'd0;
    localparam logic [1:0] ACT_CLAIM = 2'd1;
    localparam logic [1:0] ACT_ALLOC = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd1;
    localparam logic [1:0] ST_DOUBLE_CLAIM = 2'd2;
    localparam logic [1:0] ST_EMPTY       = 2'd3;

    localparam int BIT_W = 5;
    localparam int BITS_PER_WORD = 32;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  order_index;
        logic [10:0] block_index;
    } req_t;

    typedef struct packed {
        logic [10:0] granted_block;
        logic [1:0]  status;
    } rsp_t;

    // Datapath commands, one per controller step.
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,   // latch request, read head
        CMD_RD,     // read word bits and links
        CMD_EXEC,   // decide and write word / head
        CMD_PATCH1, // patch first neighbor link
        CMD_PATCH2  // patch second neighbor link
    } cmd_t;

    typedef struct packed {
        logic done;   // result known after EXEC, no patches needed
    } stat_t;
endpackage

### rtl/ofbl_if.sv
// ----------------------------------------------------------------------------
// ofbl_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface ofbl_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ofbl_ctrl.sv
// ----------------------------------------------------------------------------
// ofbl_ctrl
// Sequencer stepping each item through read, execute and link patches.
// ----------------------------------------------------------------------------
module ofbl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  ofbl_pkg::stat_t stat,
    output ofbl_pkg::cmd_t cmd
);
    import ofbl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_P1   = 3'd3;
    localparam logic [2:0] S_P2   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       fin;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = CMD_IDLE;
        fin = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd = CMD_RD;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd = CMD_EXEC;
                if (stat.done)
                begin
                    fin = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                cmd = CMD_PATCH1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd = CMD_PATCH2;
                fin = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        ov_next = fin ? 1'b1 : (ov_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

### rtl/ofbl_dp.sv
// ----------------------------------------------------------------------------
// ofbl_dp
// Bitmap and link memories with the per-item update logic.
// ----------------------------------------------------------------------------
module ofbl_dp #(
    parameter int NUM_ORDERS = 8,
    parameter int WORDS_PER_ORDER = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ofbl_pkg::cmd_t  cmd,
    input  ofbl_pkg::req_t  req,
    output ofbl_pkg::stat_t stat,
    output ofbl_pkg::rsp_t  rsp
);
    import ofbl_pkg::*;

    localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int LW = $clog2(WORDS_PER_ORDER + 1);
    localparam int TOTAL = NUM_ORDERS * WORDS_PER_ORDER;
    localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CW = $clog2(TOTAL + 1);
    localparam logic [LW-1:0] NONE = LW'(WORDS_PER_ORDER);

    // Memories are cleared by a sweep; clr_cnt_reg reaching TOTAL means ready.
    logic [31:0]   bits_mem [TOTAL];
    logic [LW-1:0] prev_mem [TOTAL];
    logic [LW-1:0] next_mem [TOTAL];
    logic [LW-1:0] head_reg [NUM_ORDERS];
    logic [CW-1:0] clr_cnt_reg;

    logic [1:0]    act_reg;
    logic [OW-1:0] ord_reg;
    logic [10:0]   blk_reg;
    logic          ord_bad_reg;
    logic [10:0]   tgt_reg;
    logic [31:0]   bits_rd_reg;
    logic [LW-1:0] prev_rd_reg, next_rd_reg, headv_reg;
    logic [1:0]    status_reg;
    logic [10:0]   granted_reg;
    logic          p1_en_reg, p2_en_reg;
    logic          p1_is_next_reg;
    logic [LW-1:0] p1_word_reg, p1_val_reg, p2_word_reg, p2_val_reg;

    logic [AW-1:0] slot_rd;
    logic [10:0]   tgt_c;
    logic [31:0]   bitm;
    logic [4:0]    low_i;
    logic [4:0]    bit_sel;
    logic          bad_word;

    assign rsp.granted_block = granted_reg;
    assign rsp.status = status_reg;

    function automatic logic [AW-1:0] slot_of(input logic [OW-1:0] o, input logic [LW-1:0] w);
        slot_of = AW'(o * WORDS_PER_ORDER + w);
    endfunction

    always_comb
    begin
        low_i = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (bits_rd_reg[i])
            begin
                low_i = 5'(i);
            end
        end
    end

    // Target block: allocate uses the head word (bits read in RD).
    always_comb
    begin
        tgt_c = blk_reg;
        if (act_reg == ACT_ALLOC)
        begin
            tgt_c = 11'(headv_reg * BITS_PER_WORD);
        end
        slot_rd = slot_of(ord_reg, LW'(tgt_c >> BIT_W));
    end

    // Allocate works on the lowest set bit of the head word.
    assign bit_sel = (act_reg == ACT_ALLOC) ? low_i : tgt_reg[BIT_W-1:0];
    assign bitm = 32'd1 << bit_sel;
    assign bad_word = (32'(tgt_reg >> BIT_W) >= 32'(WORDS_PER_ORDER));
    assign stat.done = ord_bad_reg || bad_word || (act_reg == ACT_NOP)
                       || (act_reg == ACT_ALLOC && headv_reg == NONE)
                       || (act_reg == ACT_FREE && ((bits_rd_reg & bitm) != 32'd0
                                                   || bits_rd_reg != 32'd0))
                       || (act_reg != ACT_FREE && (((bits_rd_reg & bitm) == 32'd0)
                                                   || (bits_rd_reg & ~bitm) != 32'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i] <= NONE;
            end
        end
        else if (clr_cnt_reg != CW'(TOTAL))
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
        else if (cmd == CMD_EXEC && !ord_bad_reg && !bad_word)
        begin
            if (act_reg == ACT_FREE && (bits_rd_reg & bitm) == 32'd0
                && bits_rd_reg == 32'd0)
            begin
                head_reg[ord_reg] <= LW'(tgt_reg >> BIT_W);
            end
            else if (act_reg != ACT_FREE && act_reg != ACT_NOP
                     && !(act_reg == ACT_ALLOC && headv_reg == NONE)
                     && (bits_rd_reg & bitm) != 32'd0 && (bits_rd_reg & ~bitm) == 32'd0
                     && prev_rd_reg == NONE && headv_reg == LW'(tgt_reg >> BIT_W))
            begin
                head_reg[ord_reg] <= next_rd_reg;
            end
        end
    end

    // Memory writes: clear sweep, EXEC word update, and link patches.
    always_ff @(posedge clk)
    begin
        if (clr_cnt_reg != CW'(TOTAL))
        begin
            bits_mem[clr_cnt_reg[AW-1:0]] <= 32'd0;
            prev_mem[clr_cnt_reg[AW-1:0]] <= NONE;
            next_mem[clr_cnt_reg[AW-1:0]] <= NONE;
        end
        else if (cmd == CMD_EXEC && !stat.done)
        begin
            if (act_reg == ACT_FREE)
            begin
                bits_mem[slot_rd] <= bitm;
                prev_mem[slot_rd] <= NONE;
                next_mem[slot_rd] <= headv_reg;
            end
            else
            begin
                bits_mem[slot_rd] <= 32'd0;
                prev_mem[slot_rd] <= NONE;
                next_mem[slot_rd] <= NONE;
            end
        end
        else if (cmd == CMD_EXEC && !ord_bad_reg && !bad_word && act_reg != ACT_NOP
                 && !(act_reg == ACT_ALLOC && headv_reg == NONE))
        begin
            // Bit update on a word that stays in its list state.
            if (act_reg == ACT_FREE && (bits_rd_reg & bitm) == 32'd0)
            begin
                bits_mem[slot_rd] <= bits_rd_reg | bitm;
            end
            else if (act_reg != ACT_FREE && (bits_rd_reg & bitm) != 32'd0)
            begin
                bits_mem[slot_rd] <= bits_rd_reg & ~bitm;
            end
        end
        else if (cmd == CMD_PATCH1 && p1_en_reg)
        begin
            if (p1_is_next_reg)
            begin
                next_mem[slot_of(ord_reg, p1_word_reg)] <= p1_val_reg;
            end
            else
            begin
                prev_mem[slot_of(ord_reg, p1_word_reg)] <= p1_val_reg;
            end
        end
        else if (cmd == CMD_PATCH2 && p2_en_reg)
        begin
            prev_mem[slot_of(ord_reg, p2_word_reg)] <= p2_val_reg;
        end
    end

    // Registered reads and request bookkeeping.
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                act_reg <= req.action;
                ord_reg <= OW'(req.order_index);
                blk_reg <= req.block_index;
                ord_bad_reg <= (32'(req.order_index) >= 32'(NUM_ORDERS));
                headv_reg <= (32'(req.order_index) >= 32'(NUM_ORDERS)) ? NONE
                             : head_reg[OW'(req.order_index)];
            end
            CMD_RD:
            begin
                bits_rd_reg <= bits_mem[slot_rd];
                prev_rd_reg <= prev_mem[slot_rd];
                next_rd_reg <= next_mem[slot_rd];
                tgt_reg <= tgt_c;
            end
            CMD_EXEC:
            begin
                granted_reg <= blk_reg;
                status_reg <= ST_OK;
                p1_en_reg <= 1'b0;
                p2_en_reg <= 1'b0;
                if (ord_bad_reg || bad_word)
                begin
                    status_reg <= ST_EMPTY;
                end
                else if (act_reg == ACT_NOP)
                begin
                    status_reg <= ST_OK;
                end
                else if (act_reg == ACT_FREE)
                begin
                    if ((bits_rd_reg & bitm) != 32'd0)
                    begin
                        status_reg <= ST_DOUBLE_FREE;
                    end
                    else if (bits_rd_reg == 32'd0)
                    begin
                        p1_en_reg <= (headv_reg != NONE);
                        p1_is_next_reg <= 1'b0;
                        p1_word_reg <= headv_reg;
                        p1_val_reg <= LW'(tgt_reg >> BIT_W);
                    end
                end
                else if (act_reg == ACT_ALLOC && headv_reg == NONE)
                begin
                    status_reg <= ST_EMPTY;
                end
                else if (act_reg == ACT_ALLOC && bits_rd_reg == 32'd0)
                begin
                    status_reg <= ST_EMPTY;
                end
                else
                begin
                    if (act_reg == ACT_ALLOC)
                    begin
                        granted_reg <= tgt_reg | 11'(low_i);
                    end
                    if (act_reg == ACT_CLAIM && (bits_rd_reg & bitm) == 32'd0)
                    begin
                        status_reg <= ST_DOUBLE_CLAIM;
                    end
                    else if ((bits_rd_reg & ~bitm) == 32'd0)
                    begin
                        p1_en_reg <= (prev_rd_reg != NONE);
                        p1_is_next_reg <= 1'b1;
                        p1_word_reg <= prev_rd_reg;
                        p1_val_reg <= next_rd_reg;
                        p2_en_reg <= (next_rd_reg != NONE);
                        p2_word_reg <= next_rd_reg;
                        p2_val_reg <= prev_rd_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

### rtl/order_free_bitmap_list.sv
// ----------------------------------------------------------------------------
// order_free_bitmap_list
// Free-block bitmaps of a buddy allocator, one linked word list per order.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req (action, order_index, block_index) and one result
// item (granted_block, status) leaves on rsp for every request item.
// The result is valid after the read and execute steps when no link
// changes, and after the further link patch steps when a word enters or
// leaves its order's list; the patch steps update the neighbor links
// through the single write port of the link memories.
// The result is held in an output register until taken; a new item is
// accepted in the cycle after the result has been taken, so an item is
// never accepted while an earlier one is still in progress.
// After reset the block clears all NUM_ORDERS*WORDS_PER_ORDER words (512
// by default) of the bitmap and link memories, one word per cycle; items
// that arrive meanwhile are only processed after the sweep. Every block
// starts out used.
// A stalled receiver holds the result and blocks further items.
// ----------------------------------------------------------------------------
module order_free_bitmap_list #(
    parameter int NUM_ORDERS = 8,
    parameter int WORDS_PER_ORDER = 64
) (
    input logic clk,
    input logic rst_n,
    ofbl_if.sink   req,
    ofbl_if.source rsp
);
    import ofbl_pkg::*;

    localparam int CW = $clog2(NUM_ORDERS * WORDS_PER_ORDER + 1);

    cmd_t  cmd;
    stat_t stat;
    rsp_t  rsp_d;
    logic  in_ready_c;
    logic [CW-1:0] sweep_reg;
    logic  swept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (!swept)
        begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end
    assign swept = (sweep_reg == CW'(NUM_ORDERS * WORDS_PER_ORDER));
    assign req.ready = in_ready_c && swept;

    ofbl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid && swept), .in_ready(in_ready_c),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(stat), .cmd(cmd)
    );

    ofbl_dp #(.NUM_ORDERS(NUM_ORDERS), .WORDS_PER_ORDER(WORDS_PER_ORDER)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(req.data),
        .stat(stat), .rsp(rsp_d)
    );
    assign rsp.data = rsp_d;
endmodule

### rtl/ofbl_checker.sv
// ----------------------------------------------------------------------------
// ofbl_checker
// Port-level checks on request and result handshakes.
// ----------------------------------------------------------------------------
`include "order_free_bitmap_list_defines.svh"
module ofbl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [12:0] rsp_data
);
    // A result never coexists with readiness for a new item.
    `OFBL_ASSERT_ALWAYS(a_no_ready_with_rsp, clk, rst_n, !(rsp_valid && req_ready))
    // No result appears in the cycle right after an accept.
    `OFBL_ASSERT_NEXT(a_min_latency, clk, rst_n, req_valid && req_ready, !rsp_valid)
    // A stalled result holds.
    `OFBL_ASSERT_NEXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready,
                      rsp_valid && $stable(rsp_data))
    // After an accept the block is busy.
    `OFBL_ASSERT_NEXT(a_busy, clk, rst_n, req_valid && req_ready, !req_ready)
endmodule

bind order_free_bitmap_list ofbl_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_data(rsp.data)
);

### tb/sv/order_free_bitmap_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_free_bitmap_list_tb
// Drives free, claim, allocate and unused-code requests into the order
// bitmap lists and checks every result item against a behavioral copy of
// the bitmaps and the per-order word lists kept inside the testbench.
// ----------------------------------------------------------------------------
module order_free_bitmap_list_tb;
    import ofbl_pkg::*;

    localparam int N_ORD = 8;
    localparam int N_WORD = 64;
    localparam int N_SLOT = N_ORD * N_WORD;
    localparam logic [6:0] NO_LINK = 7'(N_WORD);
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    ofbl_if #(.T(req_t)) req ();
    ofbl_if #(.T(rsp_t)) rsp ();

    order_free_bitmap_list uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    // Predictor state.
    logic [31:0] bitmap [N_SLOT];
    logic [6:0]  prv [N_SLOT];
    logic [6:0]  nxt [N_SLOT];
    logic [6:0]  head [N_ORD];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int mismatches;
    int idle_cycles;
    bit stim_done;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int slot_of(logic [2:0] o, logic [6:0] w);
        return int'(o) * N_WORD + int'(w);
    endfunction

    function automatic logic [1:0] claim_block(logic [2:0] o, logic [10:0] b);
        logic [6:0] w;
        logic [31:0] m;
        logic [6:0] pv;
        logic [6:0] nx;
        int s;
        w = {1'b0, b[10:5]};
        m = 32'd1 << b[4:0];
        s = slot_of(o, w);
        if ((bitmap[s] & m) == 0)
            return ST_DOUBLE_CLAIM;
        bitmap[s] &= ~m;
        if (bitmap[s] == 0)
        begin
            pv = prv[s];
            nx = nxt[s];
            if (pv < NO_LINK)
                nxt[slot_of(o, pv)] = nx;
            else if (head[o] == w)
                head[o] = nx;
            if (nx < NO_LINK)
                prv[slot_of(o, nx)] = pv;
            prv[s] = NO_LINK;
            nxt[s] = NO_LINK;
        end
        return ST_OK;
    endfunction

    function automatic rsp_t predict_bitmap_op(req_t r);
        rsp_t res;
        logic [6:0] w;
        logic [31:0] m;
        logic [31:0] bits;
        int s;
        int i;
        res.granted_block = r.block_index;
        res.status = ST_OK;
        w = {1'b0, r.block_index[10:5]};
        m = 32'd1 << r.block_index[4:0];
        if (r.action == ACT_FREE)
        begin
            s = slot_of(r.order_index, w);
            if ((bitmap[s] & m) != 0)
                res.status = ST_DOUBLE_FREE;
            else
            begin
                if (bitmap[s] == 0)
                begin
                    prv[s] = NO_LINK;
                    nxt[s] = head[r.order_index];
                    if (head[r.order_index] < NO_LINK)
                        prv[slot_of(r.order_index, head[r.order_index])] = w;
                    head[r.order_index] = w;
                end
                bitmap[s] |= m;
            end
        end
        else if (r.action == ACT_CLAIM)
            res.status = claim_block(r.order_index, r.block_index);
        else if (r.action == ACT_ALLOC)
        begin
            bits = (head[r.order_index] < NO_LINK) ?
                bitmap[slot_of(r.order_index, head[r.order_index])] : 32'd0;
            if (bits == 0)
                res.status = ST_EMPTY;
            else
            begin
                i = 0;
                while (bits[i] == 1'b0)
                    i++;
                res.granted_block = {head[r.order_index][5:0], 5'(i)};
                res.status = claim_block(r.order_index, res.granted_block);
                if (res.status != ST_OK)
                    res.granted_block = r.block_index;
            end
        end
        return res;
    endfunction

    // Driver.
    int drv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data <= '0;
            drv_gap = 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid && req.ready)
                drv_gap = gap_len();
            if (drv_gap > 0 || pending_reqs.size() == 0)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                req.valid <= 1'b0;
            end
            else
            begin
                req.valid <= 1'b1;
                req.data <= pending_reqs.pop_front();
            end
        end
    end

    // Prediction on acceptance, result checking and sink stalls.
    int rcv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rcv_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (req.valid && req.ready)
            begin
                expected_rsps.push_back(predict_bitmap_op(req.data));
                idle_cycles = 0;
            end
            if (rsp.valid && rsp.ready)
            begin
                idle_cycles = 0;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: granted %0d status %0d",
                            rsp.data.granted_block, rsp.data.status);
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp.data.granted_block !== exp_r.granted_block ||
                        rsp.data.status !== exp_r.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: granted %0d/%0d status %0d/%0d (exp/act)",
                                exp_r.granted_block, rsp.data.granted_block,
                                exp_r.status, rsp.data.status);
                    end
                end
                rcv_gap = gap_len();
            end
            if (rcv_gap > 0)
            begin
                rcv_gap--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic req_t mk(logic [1:0] a, logic [2:0] o, logic [10:0] b);
        req_t r;
        r.action = a;
        r.order_index = o;
        r.block_index = b;
        return r;
    endfunction

    task automatic add_random_mix(int count);
        logic [2:0] o;
        logic [10:0] b;
        int r;
        // Blocks mostly come from a narrow window so frees and claims collide
        // and words go in and out of the lists often.
        for (int k = 0; k < count; k++)
        begin
            o = 3'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 70)
                b = 11'($urandom_range(0, 3) * 32 + $urandom_range(0, 5));
            else if (r < 90)
                b = 11'($urandom_range(0, 2047));
            else
                b = 11'($urandom_range(1984, 2047));
            r = $urandom_range(0, 99);
            if (r < 40)
                pending_reqs.push_back(mk(ACT_FREE, o, b));
            else if (r < 65)
                pending_reqs.push_back(mk(ACT_CLAIM, o, b));
            else if (r < 97)
                pending_reqs.push_back(mk(ACT_ALLOC, o, b));
            else
                pending_reqs.push_back(mk(ACT_NONE, o, b));
        end
    endtask

    initial
    begin
        mismatches = 0;
        for (int s = 0; s < N_SLOT; s++)
        begin
            bitmap[s] = '0;
            prv[s] = NO_LINK;
            nxt[s] = NO_LINK;
        end
        for (int o = 0; o < N_ORD; o++)
            head[o] = NO_LINK;
        rst_n = 1'b0;

        // Directed: empty order, double free, double claim, all extremes, word
        // list unlink from the head, unused action code.
        pending_reqs.push_back(mk(ACT_ALLOC, 3'd0, 11'd2047));
        pending_reqs.push_back(mk(ACT_CLAIM, 3'd7, 11'd0));
        pending_reqs.push_back(mk(ACT_FREE, 3'd7, 11'd2047));
        pending_reqs.push_back(mk(ACT_FREE, 3'd7, 11'd2047));
        pending_reqs.push_back(mk(ACT_FREE, 3'd7, 11'd0));
        pending_reqs.push_back(mk(ACT_FREE, 3'd7, 11'd1000));
        pending_reqs.push_back(mk(ACT_FREE, 3'd7, 11'd31));
        pending_reqs.push_back(mk(ACT_CLAIM, 3'd7, 11'd1000));
        pending_reqs.push_back(mk(ACT_ALLOC, 3'd7, 11'd5));
        pending_reqs.push_back(mk(ACT_ALLOC, 3'd7, 11'd5));
        pending_reqs.push_back(mk(ACT_ALLOC, 3'd7, 11'd5));
        pending_reqs.push_back(mk(ACT_ALLOC, 3'd7, 11'd1365));
        pending_reqs.push_back(mk(ACT_NONE, 3'd5, 11'd1365));
        pending_reqs.push_back(mk(ACT_FREE, 3'd0, 11'd682));
        pending_reqs.push_back(mk(ACT_CLAIM, 3'd0, 11'd682));
        pending_reqs.push_back(mk(ACT_CLAIM, 3'd0, 11'd682));
        pending_reqs.push_back(mk(ACT_NONE, 3'd2, 11'd0));
        add_random_mix(1950);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !req.valid && expected_rsps.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/ofbl_pkg.sv
rtl/ofbl_if.sv
rtl/ofbl_ctrl.sv
rtl/ofbl_dp.sv
rtl/order_free_bitmap_list.sv
rtl/ofbl_checker.sv
tb/sv/order_free_bitmap_list_tb.sv
